// ----- src/jrpi_pkg.sv -----
// ----------------------------------------------------------------------------
// Joystick rate/position integrator package
// Shared types, widths and constants of the joystick rate/position integrator.
// ----------------------------------------------------------------------------
package jrpi_pkg;

    localparam int OVERSAMPLE = 10;

    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 14;
    localparam int COUNT_W  = 4;
    localparam int MS_W     = 16;
    localparam int SENS_W   = 12;
    localparam int DZI_W    = 11;
    localparam int LIM_W    = 16;
    localparam int POS_W    = 48;
    localparam int RMAG_W   = 13;
    localparam int PROD_W   = 29;
    localparam int QUO_W    = 38;
    localparam int REM_W    = 10;
    localparam int DIV_W    = 11;
    localparam int STEP_W   = 6;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int NUM_AXES = 3;

    localparam logic [DIV_W-1:0]  DIV_AVG = DIV_W'(OVERSAMPLE);
    localparam logic [DIV_W-1:0]  DIV_POS = DIV_W'(1000);

    localparam logic [STEP_W-1:0] AVG_LAST  = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0] MUL1_LAST = STEP_W'(SENS_W - 1);
    localparam logic [STEP_W-1:0] MUL2_LAST = STEP_W'(MS_W - 1);
    localparam logic [STEP_W-1:0] QDIV_LAST = STEP_W'(POS_W - 1);

    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam logic [SENS_W-1:0]   SENS_RESET   = SENS_W'(400);
    localparam logic [SAMPLE_W-1:0] CENTRE_RESET = SAMPLE_W'(512);
    localparam logic [LIM_W-1:0]    LIM_LO_RESET = {1'b1, {(LIM_W-1){1'b0}}};
    localparam logic [LIM_W-1:0]    LIM_HI_RESET = {1'b0, {(LIM_W-1){1'b1}}};

    typedef enum logic [0:0] {
        OP_READ = 1'b0,
        OP_CAL  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_SENS  = 3'd0,
        REG_DZI   = 3'd1,
        REG_X_MIN = 3'd2,
        REG_X_MAX = 3'd3,
        REG_Y_MIN = 3'd4,
        REG_Y_MAX = 3'd5,
        REG_R_MIN = 3'd6,
        REG_R_MAX = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_AVG,
        ST_EVAL,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_QDIV,
        ST_CLAMP,
        ST_DONE
    } t_state;

endpackage

// ----- src/joystick_rate_position_integrator.sv -----
// An item that does not close a group is absorbed while the block stays idle.
// An item that closes a calibrate group loads, averages and sets the centre of each axis.
// An item that closes a read group also multiplies, accumulates, divides and clamps each axis,
// one shared bit-serial divider and one shift-add multiplier walking the axes in turn.
// Reset is synchronous, active low: registers return to defaults, centres to 512,
// positions to zero, and the first read after reset integrates no elapsed time.
// ----------------------------------------------------------------------------
// Joystick rate/position integrator
// Averages oversampled three-axis samples, applies centre, dead zone and
// sensitivity, and integrates the rate into clamped milli-unit positions.
// ----------------------------------------------------------------------------
module joystick_rate_position_integrator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [jrpi_pkg::ADDR_W-1:0]    paddr,
    input  logic [jrpi_pkg::DATA_W-1:0]    pwdata,
    output logic [jrpi_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    // Sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic [jrpi_pkg::SAMPLE_W-1:0]  i_x_sample,
    input  logic [jrpi_pkg::SAMPLE_W-1:0]  i_y_sample,
    input  logic [jrpi_pkg::SAMPLE_W-1:0]  i_r_sample,
    input  logic [jrpi_pkg::MS_W-1:0]      i_elapsed_ms,
    // Position channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [jrpi_pkg::LIM_W-1:0] o_x_pos,
    output logic signed [jrpi_pkg::LIM_W-1:0] o_y_pos,
    output logic signed [jrpi_pkg::LIM_W-1:0] o_r_pos
);
    import jrpi_pkg::*;

    // Configuration registers
    logic [SENS_W-1:0]   r_sens;
    logic [DZI_W-1:0]    r_dzi;
    logic [LIM_W-1:0]    r_lim_lo [NUM_AXES];
    logic [LIM_W-1:0]    r_lim_hi [NUM_AXES];

    // Control and state
    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_first, n_first;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_axis, n_axis;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [SUM_W-1:0]    r_sum    [NUM_AXES];
    logic [SUM_W-1:0]    n_sum    [NUM_AXES];
    logic [SAMPLE_W-1:0] r_centre [NUM_AXES];
    logic [SAMPLE_W-1:0] n_centre [NUM_AXES];
    logic [POS_W-1:0]    r_pos    [NUM_AXES];
    logic [POS_W-1:0]    n_pos    [NUM_AXES];

    // Payload and datapath
    t_op                 r_op, n_op;
    logic [MS_W-1:0]     r_ms, n_ms;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [POS_W-1:0]    r_quo, n_quo;
    logic [PROD_W-1:0]   r_acc, n_acc;
    logic [PROD_W-1:0]   r_mcand, n_mcand;
    logic [MS_W-1:0]     r_mplier, n_mplier;
    logic                r_neg, n_neg;
    logic                r_pneg, n_pneg;
    logic [LIM_W-1:0]    r_res [NUM_AXES];
    logic [LIM_W-1:0]    n_res [NUM_AXES];
    logic [LIM_W-1:0]    r_x_pos, r_y_pos, r_r_pos;
    logic [LIM_W-1:0]    n_x_pos, n_y_pos, n_r_pos;

    // Handshake helpers
    logic                in_accept;
    logic                cfg_write;
    logic                out_free;
    logic                last_item;
    logic                axis_last;
    logic                step_last;
    logic [STEP_W-1:0]   step_end;
    logic [SUM_W-1:0]    sum_next [NUM_AXES];
    logic [SAMPLE_W-1:0] samples  [NUM_AXES];

    // Shared divider step
    logic [DIV_W-1:0]    div_const;
    logic [DIV_W-1:0]    div_trial;
    logic                div_ge;
    logic [DIV_W-1:0]    div_diff;

    // Shift-add multiplier step
    logic [PROD_W-1:0]   acc_step;

    // Per-axis evaluation
    logic [SAMPLE_W-1:0]     avg;
    logic signed [SAMPLE_W:0] dev;
    logic [SAMPLE_W-1:0]     dev_mag;
    logic [SAMPLE_W-1:0]     rate_in;
    logic [POS_W:0]          delta;
    logic [POS_W:0]          pos_sum;
    logic [POS_W-1:0]        pos_sat;
    logic [QUO_W:0]          q_ext;
    logic signed [QUO_W:0]   q_signed;
    logic signed [QUO_W:0]   lim_lo_ext;
    logic signed [QUO_W:0]   lim_hi_ext;
    logic [LIM_W-1:0]        clamped;

    assign in_accept = i_in_valid && !o_in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_item = (r_count == COUNT_W'(OVERSAMPLE - 1));
    assign axis_last = (r_axis == 2'(NUM_AXES - 1));

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_x_pos     = r_x_pos;
    assign o_y_pos     = r_y_pos;
    assign o_r_pos     = r_r_pos;
    assign pready      = 1'b1;

    assign samples[0] = i_x_sample;
    assign samples[1] = i_y_sample;
    assign samples[2] = i_r_sample;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            sum_next[k] = r_sum[k] + SUM_W'(samples[k]);
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_SENS:  prdata = DATA_W'(r_sens);
            REG_DZI:   prdata = DATA_W'(r_dzi);
            REG_X_MIN: prdata = DATA_W'($signed(r_lim_lo[0]));
            REG_X_MAX: prdata = DATA_W'($signed(r_lim_hi[0]));
            REG_Y_MIN: prdata = DATA_W'($signed(r_lim_lo[1]));
            REG_Y_MAX: prdata = DATA_W'($signed(r_lim_hi[1]));
            REG_R_MIN: prdata = DATA_W'($signed(r_lim_lo[2]));
            REG_R_MAX: prdata = DATA_W'($signed(r_lim_hi[2]));
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_AVG:  step_end = AVG_LAST;
            ST_MUL1: step_end = MUL1_LAST;
            ST_MUL2: step_end = MUL2_LAST;
            ST_QDIV: step_end = QDIV_LAST;
            default: step_end = '0;
        endcase
    end
    assign step_last = (r_step == step_end);

    // One quotient bit per cycle: the running remainder never exceeds the divisor.
    assign div_const = (r_state == ST_AVG) ? DIV_AVG : DIV_POS;
    assign div_trial = {r_rem, r_quo[POS_W-1]};
    assign div_ge    = (div_trial >= div_const);
    assign div_diff  = div_trial - div_const;

    assign acc_step = r_acc + (r_mplier[0] ? r_mcand : '0);

    // Dead zone and sign of the per-axis deflection.
    assign avg     = r_quo[SAMPLE_W-1:0];
    assign dev     = $signed({1'b0, r_centre[r_axis]}) - $signed({1'b0, avg});
    assign dev_mag = dev[SAMPLE_W] ? SAMPLE_W'(-dev) : dev[SAMPLE_W-1:0];
    assign rate_in = (dev_mag < {1'b0, r_dzi[SAMPLE_W-1:1]}) ? '0 : dev_mag;

    // Saturating position update.
    always_comb begin
        delta   = r_neg ? ((POS_W+1)'(~{(POS_W+1-PROD_W)'(0), r_acc}) + (POS_W+1)'(1))
                        : {(POS_W+1-PROD_W)'(0), r_acc};
        pos_sum = {r_pos[r_axis][POS_W-1], r_pos[r_axis]} + delta;
        if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
            pos_sat = pos_sum[POS_W] ? POS_MIN : POS_MAX;
        end else begin
            pos_sat = pos_sum[POS_W-1:0];
        end
    end

    // Signed quotient and clamp to the axis range, lower bound tested first.
    always_comb begin
        q_ext      = {1'b0, r_quo[QUO_W-1:0]};
        q_signed   = r_pneg ? $signed(~q_ext + (QUO_W+1)'(1)) : $signed(q_ext);
        lim_lo_ext = (QUO_W+1)'($signed(r_lim_lo[r_axis]));
        lim_hi_ext = (QUO_W+1)'($signed(r_lim_hi[r_axis]));
        priority if (q_signed < lim_lo_ext) begin
            clamped = r_lim_lo[r_axis];
        end else if (q_signed > lim_hi_ext) begin
            clamped = r_lim_hi[r_axis];
        end else begin
            clamped = q_signed[LIM_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_accept && last_item) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_AVG;
            ST_AVG:   if (step_last) n_state = ST_EVAL;
            ST_EVAL: begin
                if (r_op == OP_CAL) begin
                    n_state = axis_last ? ST_IDLE : ST_LOAD;
                end else begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1:  if (step_last) n_state = ST_MUL2;
            ST_MUL2:  if (step_last) n_state = ST_ACC;
            ST_ACC:   n_state = ST_QDIV;
            ST_QDIV:  if (step_last) n_state = ST_CLAMP;
            ST_CLAMP: n_state = axis_last ? ST_DONE : ST_LOAD;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_first     = r_first;
        n_axis      = r_axis;
        n_step      = r_step + STEP_W'(1);
        n_op        = r_op;
        n_ms        = r_ms;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_neg       = r_neg;
        n_pneg      = r_pneg;
        n_x_pos     = r_x_pos;
        n_y_pos     = r_y_pos;
        n_r_pos     = r_r_pos;
        n_out_valid = r_out_valid && i_out_stall;
        n_sum       = r_sum;
        n_centre    = r_centre;
        n_pos       = r_pos;
        n_res       = r_res;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_sum = sum_next;
                    if (last_item) begin
                        n_count = '0;
                        n_axis  = '0;
                        n_op    = t_op'(i_op);
                        if ((t_op'(i_op) == OP_READ) && r_first) begin
                            n_ms    = '0;
                            n_first = 1'b0;
                        end else begin
                            n_ms    = i_elapsed_ms;
                        end
                    end else begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end
            end
            ST_LOAD: begin
                n_step = '0;
                n_rem  = '0;
                n_quo  = {r_sum[r_axis], (POS_W-SUM_W)'(0)};
            end
            ST_AVG, ST_QDIV: begin
                n_rem = div_ge ? div_diff[REM_W-1:0] : div_trial[REM_W-1:0];
                n_quo = {r_quo[POS_W-2:0], div_ge};
            end
            ST_EVAL: begin
                n_step = '0;
                if (r_op == OP_CAL) begin
                    n_centre[r_axis] = avg;
                    if (axis_last) begin
                        for (int k = 0; k < NUM_AXES; k++) n_sum[k] = '0;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end else begin
                    n_neg    = dev[SAMPLE_W] ^ r_dzi[DZI_W-1];
                    n_acc    = '0;
                    n_mcand  = PROD_W'(rate_in);
                    n_mplier = MS_W'(r_sens);
                end
            end
            ST_MUL1: begin
                n_acc    = acc_step;
                n_mcand  = {r_mcand[PROD_W-2:0], 1'b0};
                n_mplier = r_mplier >> 1;
                if (step_last) begin
                    // Rate magnitude is the product over 512, truncated.
                    n_step   = '0;
                    n_acc    = '0;
                    n_mcand  = PROD_W'(acc_step[SENS_W+SAMPLE_W-1:9]);
                    n_mplier = r_ms;
                end
            end
            ST_MUL2: begin
                n_acc    = acc_step;
                n_mcand  = {r_mcand[PROD_W-2:0], 1'b0};
                n_mplier = r_mplier >> 1;
            end
            ST_ACC: begin
                n_pos[r_axis] = pos_sat;
                n_pneg = pos_sat[POS_W-1];
                n_quo  = pos_sat[POS_W-1] ? (~pos_sat + POS_W'(1)) : pos_sat;
                n_rem  = '0;
                n_step = '0;
            end
            ST_CLAMP: begin
                n_res[r_axis] = clamped;
                if (!axis_last) n_axis = r_axis + 2'd1;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_x_pos     = r_res[0];
                    n_y_pos     = r_res[1];
                    n_r_pos     = r_res[2];
                    n_out_valid = 1'b1;
                    for (int k = 0; k < NUM_AXES; k++) n_sum[k] = '0;
                end
            end
        endcase
    end

    // Control registers and stored state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
            r_sens      <= SENS_RESET;
            r_dzi       <= '0;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_lim_lo[k] <= LIM_LO_RESET;
                r_lim_hi[k] <= LIM_HI_RESET;
                r_sum[k]    <= '0;
                r_centre[k] <= CENTRE_RESET;
                r_pos[k]    <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
            r_centre    <= n_centre;
            r_pos       <= n_pos;
            if (cfg_write) begin
                unique case (t_reg_idx'(paddr[4:2]))
                    REG_SENS:  r_sens      <= pwdata[SENS_W-1:0];
                    REG_DZI:   r_dzi       <= pwdata[DZI_W-1:0];
                    REG_X_MIN: r_lim_lo[0] <= pwdata[LIM_W-1:0];
                    REG_X_MAX: r_lim_hi[0] <= pwdata[LIM_W-1:0];
                    REG_Y_MIN: r_lim_lo[1] <= pwdata[LIM_W-1:0];
                    REG_Y_MAX: r_lim_hi[1] <= pwdata[LIM_W-1:0];
                    REG_R_MIN: r_lim_lo[2] <= pwdata[LIM_W-1:0];
                    REG_R_MAX: r_lim_hi[2] <= pwdata[LIM_W-1:0];
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_axis   <= n_axis;
        r_step   <= n_step;
        r_op     <= n_op;
        r_ms     <= n_ms;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_neg    <= n_neg;
        r_pneg   <= n_pneg;
        r_res    <= n_res;
        r_x_pos  <= n_x_pos;
        r_y_pos  <= n_y_pos;
        r_r_pos  <= n_r_pos;
    end

endmodule
